@@ rtl/dbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// dbpm_pkg
// Shared types, codes and character constants of the bracket pair matcher.
// ----------------------------------------------------------------------------
package dbpm_pkg;

  // Bracket types: ( [ { < then A..Z
  localparam int unsigned TYPES_MAX = 30;
  localparam int unsigned TYPE_W    = 5;

  // Character codes
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // Output field limit (10-bit position fields saturate here)
  localparam int unsigned FIELD_MAX = 1023;

  // Type indices in ascending ASCII order of their opening character
  localparam logic [TYPE_W-1:0] ASCII_ORDER [TYPES_MAX] = '{
    5'd0,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
    5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
    5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd1,  5'd2
  };

  // Character class after decode
  typedef enum logic [1:0] {
    KIND_DOT,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_BAD
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DOT      = 3'd0,
    ST_OPEN     = 3'd1,
    ST_PAIR     = 3'd2,
    ST_UNOPENED = 3'd3,
    ST_INVALID  = 3'd4,
    ST_SKIPPED  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // Classified character handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [TYPE_W-1:0] typ;
    logic              last;
  } op_t;

  // ASCII code of the opening character of a type
  function automatic logic [6:0] open_char(input logic [TYPE_W-1:0] t);
    logic [6:0] c;
    case (t)
      5'd0:    c = CH_LPAREN[6:0];
      5'd1:    c = CH_LBRACK[6:0];
      5'd2:    c = CH_LBRACE[6:0];
      5'd3:    c = CH_LANGLE[6:0];
      default: c = CH_UP_A[6:0] + 7'(t - 5'd4);
    endcase
    return c;
  endfunction

endpackage

@@ rtl/dbpm_if.sv @@
// ----------------------------------------------------------------------------
// dbpm_in_if / dbpm_out_if
// Valid/ready channels for structure characters and match results.
// ----------------------------------------------------------------------------
interface dbpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface dbpm_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] position;
  logic [9:0] partner;
  logic [2:0] status;
  logic       unclosed;
  logic [9:0] unclosed_index;
  logic [6:0] unclosed_symbol;

  modport source (output valid, output position, output partner, output status,
                  output unclosed, output unclosed_index, output unclosed_symbol,
                  input ready);
  modport sink   (input valid, input position, input partner, input status,
                  input unclosed, input unclosed_index, input unclosed_symbol,
                  output ready);
endinterface

@@ rtl/dot_bracket_pair_matcher_unit.sv @@
// The result of a character transaction becomes valid after it has passed the
// queue and the output register.
// Throughput: one character per cycle unless the output stalls; a pop reads the
// link RAM once; its link is forwarded to a same-type operation the next cycle.
// Reset: stack valid bits, position count, error flag and queue clear at once;
// the link RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher_unit
// Multi-type dot-bracket matcher: front decode, two-entry queue, stack back end.
// ----------------------------------------------------------------------------
module dot_bracket_pair_matcher_unit #(
  parameter int unsigned MAX_LEN   = 1024,
  parameter int unsigned NUM_TYPES = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbpm_in_if.sink     in_i,
  dbpm_out_if.source  out_o
);

  logic          f_valid, f_ready;
  dbpm_pkg::op_t f_op;
  logic          b_valid, b_ready;
  dbpm_pkg::op_t b_op;

  dbpm_front #(
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .in_i       (in_i),
    .op_valid_o (f_valid),
    .op_o       (f_op),
    .op_ready_i (f_ready)
  );

  dbpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_op)
  );

  dbpm_back #(
    .MAX_LEN   (MAX_LEN),
    .NUM_TYPES (NUM_TYPES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (b_valid),
    .op_ready_o (b_ready),
    .op_i       (b_op),
    .out_o      (out_o)
  );

endmodule

@@ rtl/dbpm_ram.sv @@
// ----------------------------------------------------------------------------
// dbpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dbpm_front.sv @@
// ----------------------------------------------------------------------------
// dbpm_front
// Classifies each incoming character as dot, opener, closer or invalid.
// ----------------------------------------------------------------------------
module dbpm_front #(
  parameter int unsigned NUM_TYPES = 30
) (
  dbpm_in_if.sink        in_i,
  output logic           op_valid_o,
  output dbpm_pkg::op_t  op_o,
  input  logic           op_ready_i
);

  logic [7:0]                  sym;
  logic [dbpm_pkg::TYPE_W-1:0] t;
  dbpm_pkg::kind_e             kind;

  // Decode symbol into a bracket type and class
  always_comb begin
    sym  = in_i.symbol;
    t    = '0;
    kind = dbpm_pkg::KIND_BAD;
    if (sym == dbpm_pkg::CH_DOT) begin
      kind = dbpm_pkg::KIND_DOT;
    end else if (sym == dbpm_pkg::CH_LPAREN) begin
      kind = dbpm_pkg::KIND_OPEN;  t = 5'd0;
    end else if (sym == dbpm_pkg::CH_LBRACK) begin
      kind = dbpm_pkg::KIND_OPEN;  t = 5'd1;
    end else if (sym == dbpm_pkg::CH_LBRACE) begin
      kind = dbpm_pkg::KIND_OPEN;  t = 5'd2;
    end else if (sym == dbpm_pkg::CH_LANGLE) begin
      kind = dbpm_pkg::KIND_OPEN;  t = 5'd3;
    end else if (sym >= dbpm_pkg::CH_UP_A && sym <= dbpm_pkg::CH_UP_Z) begin
      kind = dbpm_pkg::KIND_OPEN;
      t    = 5'd4 + 5'(sym - dbpm_pkg::CH_UP_A);
    end else if (sym == dbpm_pkg::CH_RPAREN) begin
      kind = dbpm_pkg::KIND_CLOSE; t = 5'd0;
    end else if (sym == dbpm_pkg::CH_RBRACK) begin
      kind = dbpm_pkg::KIND_CLOSE; t = 5'd1;
    end else if (sym == dbpm_pkg::CH_RBRACE) begin
      kind = dbpm_pkg::KIND_CLOSE; t = 5'd2;
    end else if (sym == dbpm_pkg::CH_RANGLE) begin
      kind = dbpm_pkg::KIND_CLOSE; t = 5'd3;
    end else if (sym >= dbpm_pkg::CH_LO_A && sym <= dbpm_pkg::CH_LO_Z) begin
      kind = dbpm_pkg::KIND_CLOSE;
      t    = 5'd4 + 5'(sym - dbpm_pkg::CH_LO_A);
    end
    // Types beyond the configured set count as invalid characters
    if ((kind == dbpm_pkg::KIND_OPEN || kind == dbpm_pkg::KIND_CLOSE) &&
        32'(t) >= NUM_TYPES) begin
      kind = dbpm_pkg::KIND_BAD;
      t    = '0;
    end
  end

  assign op_valid_o = in_i.valid;
  assign op_o.kind  = kind;
  assign op_o.typ   = t;
  assign op_o.last  = in_i.last;
  assign in_i.ready = op_ready_i;

endmodule

@@ rtl/dbpm_queue.sv @@
// ----------------------------------------------------------------------------
// dbpm_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module dbpm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dbpm_pkg::op_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dbpm_pkg::op_t pop_data_o
);

  dbpm_pkg::op_t slot_q [2];
  logic [1:0]    count_q, count_d;
  logic          wr_q, rd_q;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/dbpm_back.sv @@
// ----------------------------------------------------------------------------
// dbpm_back
// Executes classified characters: per-type stacks, positions, error tracking,
// unclosed report on the last character, and the output register.
// ----------------------------------------------------------------------------
module dbpm_back #(
  parameter int unsigned MAX_LEN   = 1024,
  parameter int unsigned NUM_TYPES = 30
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  dbpm_pkg::op_t op_i,
  dbpm_out_if.source    out_o
);

  localparam int unsigned IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned POS_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned TI_W   = $clog2(NUM_TYPES);
  localparam int unsigned LINK_W = IDX_W + 1;

  // Stack state: top and second entry cached per type, deeper links in RAM
  logic [NUM_TYPES-1:0] top_v_q, top_v_d, sec_v_q, sec_v_d;
  logic [IDX_W-1:0]     top_i_q [NUM_TYPES];
  logic [IDX_W-1:0]     top_i_d [NUM_TYPES];
  logic [IDX_W-1:0]     sec_i_q [NUM_TYPES];
  logic [IDX_W-1:0]     sec_i_d [NUM_TYPES];
  logic                 pend_q, pend_d;
  logic [TI_W-1:0]      pend_t_q, pend_t_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 err_q, err_d;

  // Link RAM port signals
  logic              we, re;
  logic [LINK_W-1:0] wdata, rdata;
  logic [IDX_W-1:0]  raddr;
  logic              rd_v;
  logic [IDX_W-1:0]  rd_i;

  // Output register
  logic       out_valid_q;
  logic [9:0] position_q, position_d;
  logic [9:0] partner_q, partner_d;
  logic [2:0] status_q;
  logic       unclosed_q, unclosed_d;
  logic [9:0] uidx_q, uidx_d;
  logic [6:0] usym_q, usym_d;

  logic                        adv;
  logic [TI_W-1:0]             ti;
  logic                        eff_v;
  logic [IDX_W-1:0]            eff_i;
  dbpm_pkg::status_e           status_d;
  logic [31:0]                 pos32, part32, uidx32;
  logic                        found;
  logic [dbpm_pkg::TYPE_W-1:0] sel_t;
  logic [TI_W-1:0]             sel_ti;
  logic [dbpm_pkg::TYPE_W-1:0] ord;

  assign adv        = op_valid_i && (!out_valid_q || out_o.ready);
  assign op_ready_o = adv;
  assign ti         = op_i.typ[TI_W-1:0];
  assign rd_v       = rdata[LINK_W-1];
  assign rd_i       = rdata[IDX_W-1:0];

  dbpm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_LEN)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Item execution and next stack state
  always_comb begin
    top_v_d  = top_v_q;
    top_i_d  = top_i_q;
    sec_v_d  = sec_v_q;
    sec_i_d  = sec_i_q;
    pend_d   = 1'b0;
    pend_t_d = pend_t_q;
    pos_d    = pos_q;
    err_d    = err_q;
    we       = 1'b0;
    re       = 1'b0;
    wdata    = {top_v_q[ti], top_i_q[ti]};
    raddr    = '0;
    status_d = dbpm_pkg::ST_SKIPPED;
    part32   = '0;

    // A link fetched last cycle lands in the second slot of its type
    if (pend_q) begin
      sec_v_d[pend_t_q] = rd_v;
      sec_i_d[pend_t_q] = rd_i;
    end

    // Second entry with forwarding of an in-flight fetch
    if (pend_q && pend_t_q == ti) begin
      eff_v = rd_v;
      eff_i = rd_i;
    end else begin
      eff_v = sec_v_q[ti];
      eff_i = sec_i_q[ti];
    end

    if (adv) begin
      if (err_q) begin
        status_d = dbpm_pkg::ST_SKIPPED;
      end else if (pos_q >= POS_W'(MAX_LEN)) begin
        status_d = dbpm_pkg::ST_OVERFLOW;
        err_d    = 1'b1;
      end else begin
        case (op_i.kind)
          dbpm_pkg::KIND_DOT: begin
            status_d = dbpm_pkg::ST_DOT;
          end
          dbpm_pkg::KIND_OPEN: begin
            // Push: old top is linked under the new position
            we           = 1'b1;
            sec_v_d[ti]  = top_v_q[ti];
            sec_i_d[ti]  = top_i_q[ti];
            top_v_d[ti]  = 1'b1;
            top_i_d[ti]  = pos_q[IDX_W-1:0];
            status_d     = dbpm_pkg::ST_OPEN;
          end
          dbpm_pkg::KIND_CLOSE: begin
            if (!top_v_q[ti]) begin
              status_d = dbpm_pkg::ST_UNOPENED;
              err_d    = 1'b1;
            end else begin
              // Pop: second becomes top, fetch the one below it
              part32      = 32'(top_i_q[ti]);
              top_v_d[ti] = eff_v;
              top_i_d[ti] = eff_i;
              sec_v_d[ti] = 1'b0;
              if (eff_v) begin
                re       = 1'b1;
                raddr    = eff_i;
                pend_d   = 1'b1;
                pend_t_d = ti;
              end
              status_d = dbpm_pkg::ST_PAIR;
            end
          end
          default: begin
            status_d = dbpm_pkg::ST_INVALID;
            err_d    = 1'b1;
          end
        endcase
      end
      if (pos_q < POS_W'(MAX_LEN)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  // Lowest-ASCII open type after this item
  always_comb begin
    found  = 1'b0;
    sel_t  = '0;
    sel_ti = '0;
    for (int k = dbpm_pkg::TYPES_MAX - 1; k >= 0; k--) begin
      ord = dbpm_pkg::ASCII_ORDER[k];
      if (32'(ord) < NUM_TYPES) begin
        if (top_v_d[ord[TI_W-1:0]]) begin
          found  = 1'b1;
          sel_t  = ord;
          sel_ti = ord[TI_W-1:0];
        end
      end
    end
  end

  // Result fields
  always_comb begin
    pos32      = 32'(pos_q);
    position_d = (pos32 > dbpm_pkg::FIELD_MAX) ? 10'(dbpm_pkg::FIELD_MAX) : pos32[9:0];
    partner_d  = part32[9:0];
    unclosed_d = 1'b0;
    uidx_d     = '0;
    usym_d     = '0;
    uidx32     = 32'(top_i_d[sel_ti]);
    if (op_i.last && !err_d && found) begin
      unclosed_d = 1'b1;
      uidx_d     = (uidx32 > dbpm_pkg::FIELD_MAX) ? 10'(dbpm_pkg::FIELD_MAX) : uidx32[9:0];
      usym_d     = dbpm_pkg::open_char(sel_t);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_v_q     <= '0;
      sec_v_q     <= '0;
      pend_q      <= 1'b0;
      pend_t_q    <= '0;
      pos_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_t_q <= pend_t_d;
      if (adv && op_i.last) begin
        // Structure ends: clear for the next one
        top_v_q <= '0;
        sec_v_q <= '0;
        pend_q  <= 1'b0;
        pos_q   <= '0;
        err_q   <= 1'b0;
      end else begin
        top_v_q <= top_v_d;
        sec_v_q <= sec_v_d;
        pend_q  <= pend_d;
        pos_q   <= pos_d;
        err_q   <= err_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stack indices and result payload
  always_ff @(posedge clk_i) begin
    top_i_q <= top_i_d;
    sec_i_q <= sec_i_d;
    if (adv) begin
      position_q <= position_d;
      partner_q  <= partner_d;
      status_q   <= status_d;
      unclosed_q <= unclosed_d;
      uidx_q     <= uidx_d;
      usym_q     <= usym_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.position        = position_q;
  assign out_o.partner         = partner_q;
  assign out_o.status          = status_q;
  assign out_o.unclosed        = unclosed_q;
  assign out_o.unclosed_index  = uidx_q;
  assign out_o.unclosed_symbol = usym_q;

endmodule

@@ tb/sv/dbpm_checker.sv @@
// ----------------------------------------------------------------------------
// dbpm_checker
// Watches both channels of the bracket pair matcher. Every accepted character
// transaction runs through a local copy of the per-type stacks and leaves its
// expected result in a queue. Each accepted result transaction is then
// compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module dbpm_checker #(
  parameter int unsigned MAX_LEN   = 1024,
  parameter int unsigned NUM_TYPES = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  dbpm_in_if   in_ch,
  dbpm_out_if  out_ch,
  output int   err_cnt,
  output int   pending_cnt,
  output int   res_cnt,
  output int   pair_cnt,
  output int   fault_cnt,
  output int   open_left_cnt
);

  typedef struct packed {
    logic [9:0]        position;
    logic [9:0]        partner;
    dbpm_pkg::status_e status;
    logic              unclosed;
    logic [9:0]        unclosed_index;
    logic [6:0]        unclosed_symbol;
  } match_res_t;

  // Local stack state: top of each type plus a link per pushed position
  int unsigned char_pos;
  logic        stack_vld [dbpm_pkg::TYPES_MAX];
  logic [10:0] stack_at  [dbpm_pkg::TYPES_MAX];
  logic        link_vld  [MAX_LEN];
  logic [10:0] link_at   [MAX_LEN];
  logic        struct_err;

  match_res_t  match_q [$];

  // Type index of an opening character, -1 if not one
  function automatic int opener_of(input logic [7:0] c);
    if (c == dbpm_pkg::CH_LPAREN) return 0;
    if (c == dbpm_pkg::CH_LBRACK) return 1;
    if (c == dbpm_pkg::CH_LBRACE) return 2;
    if (c == dbpm_pkg::CH_LANGLE) return 3;
    if (c >= dbpm_pkg::CH_UP_A && c <= dbpm_pkg::CH_UP_Z)
      return 4 + int'(c - dbpm_pkg::CH_UP_A);
    return -1;
  endfunction

  // Type index of a closing character, -1 if not one
  function automatic int closer_of(input logic [7:0] c);
    if (c == dbpm_pkg::CH_RPAREN) return 0;
    if (c == dbpm_pkg::CH_RBRACK) return 1;
    if (c == dbpm_pkg::CH_RBRACE) return 2;
    if (c == dbpm_pkg::CH_RANGLE) return 3;
    if (c >= dbpm_pkg::CH_LO_A && c <= dbpm_pkg::CH_LO_Z)
      return 4 + int'(c - dbpm_pkg::CH_LO_A);
    return -1;
  endfunction

  task automatic clear_struct();
    char_pos   = 0;
    struct_err = 1'b0;
    for (int t = 0; t < dbpm_pkg::TYPES_MAX; t++) begin
      stack_vld[t] = 1'b0;
      stack_at[t]  = '0;
    end
  endtask

  // Expected result of one character; updates the local stacks
  task automatic predict_char(input logic [7:0] sym, input logic last,
                              output match_res_t r);
    int          ot;
    int          ct;
    int          ut;
    int unsigned j;
    r          = '0;
    r.position = (char_pos > dbpm_pkg::FIELD_MAX) ? 10'(dbpm_pkg::FIELD_MAX)
                                                  : 10'(char_pos);
    ot         = opener_of(sym);
    ct         = closer_of(sym);
    if (struct_err) begin
      r.status = dbpm_pkg::ST_SKIPPED;
    end else if (char_pos >= MAX_LEN) begin
      r.status   = dbpm_pkg::ST_OVERFLOW;
      struct_err = 1'b1;
    end else if (sym == dbpm_pkg::CH_DOT) begin
      r.status = dbpm_pkg::ST_DOT;
    end else if (ot >= 0 && ot < int'(NUM_TYPES)) begin
      // push: remember the previous top of this type
      link_vld[char_pos] = stack_vld[ot];
      link_at[char_pos]  = stack_at[ot];
      stack_vld[ot]      = 1'b1;
      stack_at[ot]       = 11'(char_pos);
      r.status           = dbpm_pkg::ST_OPEN;
    end else if (ct >= 0 && ct < int'(NUM_TYPES)) begin
      if (!stack_vld[ct]) begin
        r.status   = dbpm_pkg::ST_UNOPENED;
        struct_err = 1'b1;
      end else begin
        j             = stack_at[ct];
        r.partner     = 10'(j);
        stack_vld[ct] = link_vld[j];
        stack_at[ct]  = link_at[j];
        r.status      = dbpm_pkg::ST_PAIR;
      end
    end else begin
      r.status   = dbpm_pkg::ST_INVALID;
      struct_err = 1'b1;
    end
    if (char_pos < MAX_LEN) char_pos++;

    // end of structure: lowest ASCII opener still open, then clear
    if (last) begin
      if (!struct_err) begin
        for (int c = 0; c < 128; c++) begin
          ut = opener_of(8'(c));
          if (ut >= 0 && ut < int'(NUM_TYPES) && stack_vld[ut]) begin
            r.unclosed        = 1'b1;
            r.unclosed_index  = (stack_at[ut] > dbpm_pkg::FIELD_MAX)
                                ? 10'(dbpm_pkg::FIELD_MAX) : stack_at[ut][9:0];
            r.unclosed_symbol = 7'(c);
            break;
          end
        end
      end
      clear_struct();
    end
  endtask

  task automatic check_field(input string fname, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t checker: %s mismatch, expected %0d, actual %0d",
               $time, fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    match_res_t r;
    match_res_t exp_r;
    if (!rst_ni) begin
      clear_struct();
      match_q.delete();
      err_cnt       = 0;
      res_cnt       = 0;
      pair_cnt      = 0;
      fault_cnt     = 0;
      open_left_cnt = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_char(in_ch.symbol, in_ch.last, r);
        match_q = {match_q, r};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (match_q.size() == 0) begin
          $display("%0t checker: result with none expected, position %0d status %0d",
                   $time, out_ch.position, out_ch.status);
          err_cnt++;
        end else begin
          exp_r = match_q.pop_front();
          res_cnt++;
          check_field("position", exp_r.position, out_ch.position);
          check_field("partner", exp_r.partner, out_ch.partner);
          check_field("status", exp_r.status, out_ch.status);
          check_field("unclosed", exp_r.unclosed, out_ch.unclosed);
          check_field("unclosed_index", exp_r.unclosed_index, out_ch.unclosed_index);
          check_field("unclosed_symbol", exp_r.unclosed_symbol, out_ch.unclosed_symbol);
          if (exp_r.status == dbpm_pkg::ST_PAIR) pair_cnt++;
          if (exp_r.status inside {dbpm_pkg::ST_UNOPENED, dbpm_pkg::ST_INVALID,
                                   dbpm_pkg::ST_OVERFLOW}) fault_cnt++;
          if (exp_r.unclosed) open_left_cnt++;
        end
      end
    end
    pending_cnt = match_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the dot-bracket pair matcher. Directed structures
// hit the short-structure statuses and the unclosed report, then random
// structures follow: mostly well formed with random content, some broken by
// one bad character, and some raw byte noise.
// Both channel sides idle at random; the checker does all comparisons.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STRUCT_MAX  = 1024;
  localparam int unsigned N_TYPES     = 30;
  localparam int          RAND_ITEMS  = 700;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          TAIL_CYCLES = 8;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_acc_q  = 1'b0;
  logic out_acc_q = 1'b0;
  bit   no_idle   = 1'b0;
  int   cycle_cnt = 0;
  int   open_cnt [N_TYPES];

  int err_cnt;
  int pending_cnt;
  int res_cnt;
  int pair_cnt;
  int fault_cnt;
  int open_left_cnt;

  dbpm_in_if  in_ch ();
  dbpm_out_if out_ch ();

  dot_bracket_pair_matcher_unit #(
    .MAX_LEN  (STRUCT_MAX),
    .NUM_TYPES(N_TYPES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dbpm_checker #(
    .MAX_LEN  (STRUCT_MAX),
    .NUM_TYPES(N_TYPES)
  ) u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .err_cnt      (err_cnt),
    .pending_cnt  (pending_cnt),
    .res_cnt      (res_cnt),
    .pair_cnt     (pair_cnt),
    .fault_cnt    (fault_cnt),
    .open_left_cnt(open_left_cnt)
  );

  always #10 clk_i = ~clk_i;

  // Handshakes seen at the rising edge, read back at the falling edge
  always @(posedge clk_i) begin
    in_acc_q  <= in_ch.valid && in_ch.ready;
    out_acc_q <= out_ch.valid && out_ch.ready;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: no completion within %0d cycles", CYCLE_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic int idle_len();
    return no_idle ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic logic [7:0] opener_char(input int t);
    case (t)
      0:       return dbpm_pkg::CH_LPAREN;
      1:       return dbpm_pkg::CH_LBRACK;
      2:       return dbpm_pkg::CH_LBRACE;
      3:       return dbpm_pkg::CH_LANGLE;
      default: return dbpm_pkg::CH_UP_A + 8'(t - 4);
    endcase
  endfunction

  function automatic logic [7:0] closer_char(input int t);
    case (t)
      0:       return dbpm_pkg::CH_RPAREN;
      1:       return dbpm_pkg::CH_RBRACK;
      2:       return dbpm_pkg::CH_RBRACE;
      3:       return dbpm_pkg::CH_RANGLE;
      default: return dbpm_pkg::CH_LO_A + 8'(t - 4);
    endcase
  endfunction

  // Any byte that is neither a dot nor a bracket
  function automatic logic [7:0] bad_byte();
    logic [7:0] c;
    bit         hit;
    do begin
      c   = 8'($urandom_range(0, 255));
      hit = (c == dbpm_pkg::CH_DOT);
      for (int t = 0; t < N_TYPES; t++)
        if (c == opener_char(t) || c == closer_char(t)) hit = 1'b1;
    end while (hit);
    return c;
  endfunction

  // Favor the four classic types so same-type stacks get deep
  function automatic int pick_type();
    return ($urandom_range(0, 9) < 6) ? int'($urandom_range(0, 3))
                                      : int'($urandom_range(0, N_TYPES - 1));
  endfunction

  // One character transaction; called and returns at a falling edge
  task automatic send_char(input logic [7:0] sym, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.last   <= last;
    do @(negedge clk_i); while (!in_acc_q);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  // Random structure; close_all keeps it balanced, broken puts in one fault
  task automatic send_structure(input int len, input bit broken, input bit close_all);
    int         err_at;
    int         n_open;
    int         t;
    int         pick;
    bit         can_open;
    logic [7:0] sym;
    foreach (open_cnt[k]) open_cnt[k] = 0;
    n_open = 0;
    err_at = broken ? int'($urandom_range(0, len - 1)) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == err_at) begin
        t = $urandom_range(0, N_TYPES - 1);
        if ($urandom_range(0, 1) && open_cnt[t] == 0) sym = closer_char(t);
        else sym = bad_byte();
      end else begin
        pick     = $urandom_range(0, 9);
        can_open = !close_all || (n_open + 2 <= len - i);
        if (close_all && n_open >= len - i) pick = 9;
        else begin
          if (pick >= 3 && pick <= 5 && !can_open) pick = 0;
          if (pick >= 6 && n_open == 0) pick = can_open ? 3 : 0;
        end
        if (pick <= 2) begin
          sym = dbpm_pkg::CH_DOT;
        end else if (pick <= 5) begin
          t = pick_type();
          sym = opener_char(t);
          open_cnt[t]++;
          n_open++;
        end else begin
          t = $urandom_range(0, N_TYPES - 1);
          while (open_cnt[t] == 0) t = (t + 1) % N_TYPES;
          sym = closer_char(t);
          open_cnt[t]--;
          n_open--;
        end
      end
      send_char(sym, i == len - 1);
    end
  endtask

  // Result side: random stall before each result transaction
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk_i); while (!out_acc_q);
    end
  end

  // Stimulus and verdict
  initial begin
    int kind;
    int len;
    int rand_items;
    in_ch.valid  = 1'b0;
    in_ch.symbol = '0;
    in_ch.last   = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: short-structure statuses, ASCII order of the unclosed report
    send_text("(.)");
    send_text("[{<Z>");
    send_text("Zz");
    send_text("a(");
    send_char(8'hFF, 1'b0);
    send_text(".");
    send_text(")");
    send_text("A(A");
    send_char(8'h00, 1'b1);
    send_char(8'h80, 1'b1);
    send_char(8'h7F, 1'b1);
    drain();

    // Random structures with occasional full drains
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 19) == 0) drain();
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(25, 80))
                                         : int'($urandom_range(1, 24));
      if (kind < 7) begin
        send_structure(len, 1'b0, 1'($urandom_range(0, 1)));
      end else if (kind < 9) begin
        send_structure(len, 1'b1, 1'($urandom_range(0, 1)));
      end else begin
        len = len % 8 + 1;
        for (int i = 0; i < len; i++)
          send_char(8'($urandom_range(0, 255)),
                    (i == len - 1) || ($urandom_range(0, 3) == 0));
      end
      rand_items += len;
    end
    no_idle = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("tb: %0d results checked, %0d pairs closed, %0d faults flagged",
             res_cnt, pair_cnt, fault_cnt);
    $display("tb: %0d open-bracket reports over random structures and idling",
             open_left_cnt);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
